### rtl/core/fpa_pkg.sv
package fpa_pkg;

    localparam int FREE_SLOTS_DEF   = 16;
    localparam int OWN_SLOTS_DEF    = 16;
    localparam int ADDR_W_DEF       = 16;
    localparam int MIN_FRAGMENT_DEF = 10;

    localparam logic [15:0] TOTAL_SIZE_RST = 16'd1024;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NOMEM = 2'd1,
        STAT_NOID  = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // register index, taken from paddr bit 2
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_FIT   = 1'b1;

    localparam logic FUNC_ALLOC = 1'b0;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_AF_RD,
        S_AF_EV,
        S_AF_DEC,
        S_CP_RD,
        S_CP_EV,
        S_AF_WR,
        S_AG_RD,
        S_AG_EV,
        S_OWN_WR,
        S_FO_RD,
        S_FO_EV,
        S_FO_DEC,
        S_FF_RD,
        S_FF_EV,
        S_FF_WR,
        S_DG_RD,
        S_DG_EV,
        S_DG_END,
        S_FIN
    } state_t;

endpackage

### rtl/core/fpa_ram.sv
module fpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/partition_allocator_ff_bf_wf.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: func; s_tdata: req_size, target_pid
// m_        out  m_tvalid/m_tready  m_tuser: status; m_tdata: pid, start, size
// apb       in   psel/penable       0x0 total_size, 0x4 fit_mode
//
// Allocate scans the free table and then the owned table an entry at a time, through
// their single read ports. Compaction makes one owned-table pass per rank.
// Free scans the owned table, then the free table, then the owned table again.
// Reset (and a total_size write taken while idle) seeds free entry 0.
// A result waits in the output register; the next beat is taken once it is stored.
module partition_allocator_ff_bf_wf #(
    parameter int FREE_SLOTS   = fpa_pkg::FREE_SLOTS_DEF,
    parameter int OWN_SLOTS    = fpa_pkg::OWN_SLOTS_DEF,
    parameter int ADDR_W       = fpa_pkg::ADDR_W_DEF,
    parameter int MIN_FRAGMENT = fpa_pkg::MIN_FRAGMENT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] req_size, [23:16] target_pid
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] pid_out, [23:8] base_addr, [39:24] granted_size
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW  = $clog2(FREE_SLOTS);
    localparam int OW  = $clog2(OWN_SLOTS);
    localparam int CW  = (ADDR_W > 16) ? ADDR_W : 16;
    localparam int FDW = 2 * ADDR_W;
    localparam int ODW = 8 + 2 * ADDR_W + OW;

    fpa_pkg::state_t state_reg, state_next;

    logic [FREE_SLOTS-1:0] free_used_reg, free_used_next;
    logic [OWN_SLOTS-1:0]  own_used_reg, own_used_next;
    logic [OW:0]           own_cnt_reg, own_cnt_next;
    logic [7:0]            next_pid_reg, next_pid_next;
    logic [15:0]           total_size_reg, total_size_next;
    logic [1:0]            fit_mode_reg, fit_mode_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [FW-1:0]     fidx_reg, fidx_next;
    logic [OW-1:0]     oidx_reg, oidx_next;
    logic [15:0]       req_reg, req_next;
    logic [7:0]        tpid_reg, tpid_next;
    logic              pick_found_reg, pick_found_next;
    logic [FW-1:0]     pick_idx_reg, pick_idx_next;
    logic [ADDR_W-1:0] pick_start_reg, pick_start_next;
    logic [ADDR_W-1:0] pick_len_reg, pick_len_next;
    logic [ADDR_W-1:0] sum_reg, sum_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [OW:0]       rank_reg, rank_next;
    logic              slot_found_reg, slot_found_next;
    logic [OW-1:0]     slot_idx_reg, slot_idx_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] grant_reg, grant_next;
    logic              hit_found_reg, hit_found_next;
    logic [OW-1:0]     hit_idx_reg, hit_idx_next;
    logic [OW-1:0]     hit_age_reg, hit_age_next;
    logic              left_found_reg, left_found_next;
    logic [FW-1:0]     left_idx_reg, left_idx_next;
    logic [ADDR_W-1:0] left_start_reg, left_start_next;
    logic [ADDR_W-1:0] left_len_reg, left_len_next;
    logic              right_found_reg, right_found_next;
    logic [FW-1:0]     right_idx_reg, right_idx_next;
    logic [ADDR_W-1:0] right_len_reg, right_len_next;
    logic              fslot_found_reg, fslot_found_next;
    logic [FW-1:0]     fslot_idx_reg, fslot_idx_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [7:0]        res_pid_reg, res_pid_next;
    logic [15:0]       res_start_reg, res_start_next;
    logic [15:0]       res_size_reg, res_size_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;
    logic [1:0]        m_tuser_reg, m_tuser_next;

    // table memories
    logic              f_we;
    logic [FW-1:0]     f_waddr;
    logic [FDW-1:0]    f_wdata, f_rdata;
    logic              o_we;
    logic [OW-1:0]     o_waddr;
    logic [ODW-1:0]    o_wdata, o_rdata;

    fpa_ram #(.WIDTH(FDW), .DEPTH(FREE_SLOTS)) u_free_ram (
        .aclk  (aclk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (fidx_reg),
        .rdata (f_rdata)
    );

    fpa_ram #(.WIDTH(ODW), .DEPTH(OWN_SLOTS)) u_own_ram (
        .aclk  (aclk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (oidx_reg),
        .rdata (o_rdata)
    );

    logic [ADDR_W-1:0] f_rd_start, f_rd_len;
    logic [7:0]        o_rd_pid;
    logic [ADDR_W-1:0] o_rd_start, o_rd_len;
    logic [OW-1:0]     o_rd_age;

    assign f_rd_start = f_rdata[FDW-1:ADDR_W];
    assign f_rd_len   = f_rdata[ADDR_W-1:0];
    assign o_rd_pid   = o_rdata[ODW-1:ODW-8];
    assign o_rd_start = o_rdata[ODW-9:ADDR_W+OW];
    assign o_rd_len   = o_rdata[ADDR_W+OW-1:OW];
    assign o_rd_age   = o_rdata[OW-1:0];

    logic f_last, o_last;
    assign f_last = (fidx_reg == FW'(FREE_SLOTS - 1));
    assign o_last = (oidx_reg == OW'(OWN_SLOTS - 1));

    // fit selection against the current pick
    logic [CW-1:0] req_c, len_c, pick_len_c, af_rem;
    logic          fits, better, addr_lower;
    assign req_c      = CW'(req_reg);
    assign len_c      = CW'(f_rd_len);
    assign pick_len_c = CW'(pick_len_reg);
    assign fits       = (len_c >= req_c);
    assign addr_lower = (f_rd_start < pick_start_reg);
    assign af_rem     = pick_len_c - req_c;

    always_comb begin
        if (!pick_found_reg) begin
            better = 1'b1;
        end else if (fit_mode_reg == fpa_pkg::FIT_FIRST || f_rd_len == pick_len_reg) begin
            better = addr_lower;
        end else if (fit_mode_reg == fpa_pkg::FIT_BEST) begin
            better = (f_rd_len < pick_len_reg);
        end else begin
            better = (f_rd_len > pick_len_reg);
        end
    end

    logic [ADDR_W-1:0] hit_end;
    assign hit_end = start_reg + grant_reg;

    // configuration port
    logic cfg_wr, cfg_total_wr;
    assign pready       = 1'b1;
    assign cfg_wr       = psel && penable && pwrite;
    assign cfg_total_wr = cfg_wr && (paddr[2] == fpa_pkg::REG_TOTAL);
    assign prdata       = (paddr[2] == fpa_pkg::REG_TOTAL) ? {16'b0, total_size_reg}
                                                           : {30'b0, fit_mode_reg};

    assign s_tready = (state_reg == fpa_pkg::S_IDLE) && !cfg_total_wr;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next       = state_reg;
        free_used_next   = free_used_reg;
        own_used_next    = own_used_reg;
        own_cnt_next     = own_cnt_reg;
        next_pid_next    = next_pid_reg;
        total_size_next  = total_size_reg;
        fit_mode_next    = fit_mode_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        fidx_next        = fidx_reg;
        oidx_next        = oidx_reg;
        req_next         = req_reg;
        tpid_next        = tpid_reg;
        pick_found_next  = pick_found_reg;
        pick_idx_next    = pick_idx_reg;
        pick_start_next  = pick_start_reg;
        pick_len_next    = pick_len_reg;
        sum_next         = sum_reg;
        addr_next        = addr_reg;
        rank_next        = rank_reg;
        slot_found_next  = slot_found_reg;
        slot_idx_next    = slot_idx_reg;
        start_next       = start_reg;
        grant_next       = grant_reg;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_age_next     = hit_age_reg;
        left_found_next  = left_found_reg;
        left_idx_next    = left_idx_reg;
        left_start_next  = left_start_reg;
        left_len_next    = left_len_reg;
        right_found_next = right_found_reg;
        right_idx_next   = right_idx_reg;
        right_len_next   = right_len_reg;
        fslot_found_next = fslot_found_reg;
        fslot_idx_next   = fslot_idx_reg;
        res_status_next  = res_status_reg;
        res_pid_next     = res_pid_reg;
        res_start_next   = res_start_reg;
        res_size_next    = res_size_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        f_we             = 1'b0;
        f_waddr          = fidx_reg;
        f_wdata          = '0;
        o_we             = 1'b0;
        o_waddr          = oidx_reg;
        o_wdata          = '0;

        if (cfg_wr) begin
            if (paddr[2] == fpa_pkg::REG_TOTAL) begin
                total_size_next = pwdata[15:0];
            end else begin
                fit_mode_next = pwdata[1:0];
            end
        end

        case (state_reg)
            fpa_pkg::S_INIT: begin
                // seed the single free extent, drop all owners
                f_we              = 1'b1;
                f_waddr           = '0;
                f_wdata           = {ADDR_W'(0), ADDR_W'(total_size_reg)};
                free_used_next    = '0;
                free_used_next[0] = (total_size_reg != 16'd0);
                own_used_next     = '0;
                own_cnt_next      = '0;
                state_next        = fpa_pkg::S_IDLE;
            end
            fpa_pkg::S_IDLE: begin
                if (cfg_total_wr) begin
                    state_next = fpa_pkg::S_INIT;
                end else if (s_tvalid) begin
                    req_next       = s_tdata[15:0];
                    tpid_next      = s_tdata[23:16];
                    res_start_next = '0;
                    res_size_next  = '0;
                    if (s_tuser[0] == fpa_pkg::FUNC_ALLOC) begin
                        next_pid_next = next_pid_reg + 8'd1;
                        res_pid_next  = next_pid_reg + 8'd1;
                        if (s_tdata[15:0] == 16'd0 || own_cnt_reg == (OW+1)'(OWN_SLOTS)) begin
                            res_status_next = fpa_pkg::STAT_FULL;
                            state_next      = fpa_pkg::S_FIN;
                        end else begin
                            fidx_next       = '0;
                            pick_found_next = 1'b0;
                            sum_next        = '0;
                            state_next      = fpa_pkg::S_AF_RD;
                        end
                    end else begin
                        res_pid_next   = s_tdata[23:16];
                        oidx_next      = '0;
                        hit_found_next = 1'b0;
                        state_next     = fpa_pkg::S_FO_RD;
                    end
                end
            end
            fpa_pkg::S_AF_RD: begin
                if (free_used_reg[fidx_reg]) begin
                    state_next = fpa_pkg::S_AF_EV;
                end else if (f_last) begin
                    state_next = fpa_pkg::S_AF_DEC;
                end else begin
                    fidx_next = fidx_reg + 1'b1;
                end
            end
            fpa_pkg::S_AF_EV: begin
                if (fits && better) begin
                    pick_found_next = 1'b1;
                    pick_idx_next   = fidx_reg;
                    pick_start_next = f_rd_start;
                    pick_len_next   = f_rd_len;
                end
                sum_next = sum_reg + f_rd_len;
                if (f_last) begin
                    state_next = fpa_pkg::S_AF_DEC;
                end else begin
                    fidx_next  = fidx_reg + 1'b1;
                    state_next = fpa_pkg::S_AF_RD;
                end
            end
            fpa_pkg::S_AF_DEC: begin
                if (pick_found_reg) begin
                    state_next = fpa_pkg::S_AF_WR;
                end else if (CW'(sum_reg) < req_c) begin
                    res_status_next = fpa_pkg::STAT_NOMEM;
                    state_next      = fpa_pkg::S_FIN;
                end else begin
                    rank_next  = '0;
                    addr_next  = '0;
                    oidx_next  = '0;
                    state_next = fpa_pkg::S_CP_RD;
                end
            end
            fpa_pkg::S_CP_RD: begin
                // pack owners newest first, one rank per pass
                if (rank_reg == own_cnt_reg) begin
                    free_used_next  = '0;
                    pick_idx_next   = '0;
                    pick_start_next = addr_reg;
                    pick_len_next   = sum_reg;
                    state_next      = fpa_pkg::S_AF_WR;
                end else if (own_used_reg[oidx_reg]) begin
                    state_next = fpa_pkg::S_CP_EV;
                end else begin
                    oidx_next = o_last ? '0 : oidx_reg + 1'b1;
                end
            end
            fpa_pkg::S_CP_EV: begin
                if (o_rd_age == rank_reg[OW-1:0]) begin
                    o_we      = 1'b1;
                    o_wdata   = {o_rd_pid, addr_reg, o_rd_len, o_rd_age};
                    addr_next = addr_reg + o_rd_len;
                    rank_next = rank_reg + 1'b1;
                    oidx_next = '0;
                end else begin
                    oidx_next = o_last ? '0 : oidx_reg + 1'b1;
                end
                state_next = fpa_pkg::S_CP_RD;
            end
            fpa_pkg::S_AF_WR: begin
                f_waddr    = pick_idx_reg;
                start_next = pick_start_reg;
                if (af_rem != '0 && af_rem >= CW'(MIN_FRAGMENT)) begin
                    f_we                         = 1'b1;
                    f_wdata                      = {pick_start_reg + ADDR_W'(req_reg),
                                                    ADDR_W'(af_rem)};
                    free_used_next[pick_idx_reg] = 1'b1;
                    grant_next                   = ADDR_W'(req_reg);
                end else begin
                    free_used_next[pick_idx_reg] = 1'b0;
                    grant_next                   = pick_len_reg;
                end
                oidx_next       = '0;
                slot_found_next = 1'b0;
                state_next      = fpa_pkg::S_AG_RD;
            end
            fpa_pkg::S_AG_RD: begin
                // age every owner, spot the first empty slot
                if (own_used_reg[oidx_reg]) begin
                    state_next = fpa_pkg::S_AG_EV;
                end else begin
                    if (!slot_found_reg) begin
                        slot_found_next = 1'b1;
                        slot_idx_next   = oidx_reg;
                    end
                    if (o_last) begin
                        state_next = fpa_pkg::S_OWN_WR;
                    end else begin
                        oidx_next = oidx_reg + 1'b1;
                    end
                end
            end
            fpa_pkg::S_AG_EV: begin
                o_we    = 1'b1;
                o_wdata = {o_rd_pid, o_rd_start, o_rd_len, o_rd_age + 1'b1};
                if (o_last) begin
                    state_next = fpa_pkg::S_OWN_WR;
                end else begin
                    oidx_next  = oidx_reg + 1'b1;
                    state_next = fpa_pkg::S_AG_RD;
                end
            end
            fpa_pkg::S_OWN_WR: begin
                o_we                        = 1'b1;
                o_waddr                     = slot_idx_reg;
                o_wdata                     = {next_pid_reg, start_reg, grant_reg, OW'(0)};
                own_used_next[slot_idx_reg] = 1'b1;
                own_cnt_next                = own_cnt_reg + 1'b1;
                res_status_next             = fpa_pkg::STAT_OK;
                res_start_next              = 16'(start_reg);
                res_size_next               = 16'(grant_reg);
                state_next                  = fpa_pkg::S_FIN;
            end
            fpa_pkg::S_FO_RD: begin
                if (own_used_reg[oidx_reg]) begin
                    state_next = fpa_pkg::S_FO_EV;
                end else if (o_last) begin
                    state_next = fpa_pkg::S_FO_DEC;
                end else begin
                    oidx_next = oidx_reg + 1'b1;
                end
            end
            fpa_pkg::S_FO_EV: begin
                // oldest owner of the id wins
                if (o_rd_pid == tpid_reg && (!hit_found_reg || o_rd_age > hit_age_reg)) begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = oidx_reg;
                    hit_age_next   = o_rd_age;
                    start_next     = o_rd_start;
                    grant_next     = o_rd_len;
                end
                if (o_last) begin
                    state_next = fpa_pkg::S_FO_DEC;
                end else begin
                    oidx_next  = oidx_reg + 1'b1;
                    state_next = fpa_pkg::S_FO_RD;
                end
            end
            fpa_pkg::S_FO_DEC: begin
                if (!hit_found_reg) begin
                    res_status_next = fpa_pkg::STAT_NOID;
                    state_next      = fpa_pkg::S_FIN;
                end else begin
                    fidx_next        = '0;
                    left_found_next  = 1'b0;
                    right_found_next = 1'b0;
                    fslot_found_next = 1'b0;
                    state_next       = fpa_pkg::S_FF_RD;
                end
            end
            fpa_pkg::S_FF_RD: begin
                if (free_used_reg[fidx_reg]) begin
                    state_next = fpa_pkg::S_FF_EV;
                end else begin
                    if (!fslot_found_reg) begin
                        fslot_found_next = 1'b1;
                        fslot_idx_next   = fidx_reg;
                    end
                    if (f_last) begin
                        state_next = fpa_pkg::S_FF_WR;
                    end else begin
                        fidx_next = fidx_reg + 1'b1;
                    end
                end
            end
            fpa_pkg::S_FF_EV: begin
                if ((f_rd_start + f_rd_len) == start_reg && !left_found_reg) begin
                    left_found_next = 1'b1;
                    left_idx_next   = fidx_reg;
                    left_start_next = f_rd_start;
                    left_len_next   = f_rd_len;
                end else if (f_rd_start == hit_end && !right_found_reg) begin
                    right_found_next = 1'b1;
                    right_idx_next   = fidx_reg;
                    right_len_next   = f_rd_len;
                end
                if (f_last) begin
                    state_next = fpa_pkg::S_FF_WR;
                end else begin
                    fidx_next  = fidx_reg + 1'b1;
                    state_next = fpa_pkg::S_FF_RD;
                end
            end
            fpa_pkg::S_FF_WR: begin
                // merge with neighbors, else take a fresh slot, else report full
                oidx_next  = '0;
                state_next = fpa_pkg::S_DG_RD;
                if (left_found_reg && right_found_reg) begin
                    f_we                          = 1'b1;
                    f_waddr                       = left_idx_reg;
                    f_wdata                       = {left_start_reg,
                                                     left_len_reg + grant_reg + right_len_reg};
                    free_used_next[right_idx_reg] = 1'b0;
                end else if (left_found_reg) begin
                    f_we    = 1'b1;
                    f_waddr = left_idx_reg;
                    f_wdata = {left_start_reg, left_len_reg + grant_reg};
                end else if (right_found_reg) begin
                    f_we    = 1'b1;
                    f_waddr = right_idx_reg;
                    f_wdata = {start_reg, right_len_reg + grant_reg};
                end else if (fslot_found_reg) begin
                    f_we                          = 1'b1;
                    f_waddr                       = fslot_idx_reg;
                    f_wdata                       = {start_reg, grant_reg};
                    free_used_next[fslot_idx_reg] = 1'b1;
                end else begin
                    res_status_next = fpa_pkg::STAT_FULL;
                    state_next      = fpa_pkg::S_FIN;
                end
            end
            fpa_pkg::S_DG_RD: begin
                if (own_used_reg[oidx_reg]) begin
                    state_next = fpa_pkg::S_DG_EV;
                end else if (o_last) begin
                    state_next = fpa_pkg::S_DG_END;
                end else begin
                    oidx_next = oidx_reg + 1'b1;
                end
            end
            fpa_pkg::S_DG_EV: begin
                // close the rank gap left by the released owner
                if (o_rd_age > hit_age_reg) begin
                    o_we    = 1'b1;
                    o_wdata = {o_rd_pid, o_rd_start, o_rd_len, o_rd_age - 1'b1};
                end
                if (o_last) begin
                    state_next = fpa_pkg::S_DG_END;
                end else begin
                    oidx_next  = oidx_reg + 1'b1;
                    state_next = fpa_pkg::S_DG_RD;
                end
            end
            fpa_pkg::S_DG_END: begin
                own_used_next[hit_idx_reg] = 1'b0;
                own_cnt_next               = own_cnt_reg - 1'b1;
                res_status_next            = fpa_pkg::STAT_OK;
                res_start_next             = 16'(start_reg);
                res_size_next              = 16'(grant_reg);
                state_next                 = fpa_pkg::S_FIN;
            end
            fpa_pkg::S_FIN: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_size_reg, res_start_reg, res_pid_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = fpa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = fpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fpa_pkg::S_INIT;
            free_used_reg  <= '0;
            own_used_reg   <= '0;
            own_cnt_reg    <= '0;
            next_pid_reg   <= '0;
            total_size_reg <= fpa_pkg::TOTAL_SIZE_RST;
            fit_mode_reg   <= fpa_pkg::FIT_FIRST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_used_reg  <= free_used_next;
            own_used_reg   <= own_used_next;
            own_cnt_reg    <= own_cnt_next;
            next_pid_reg   <= next_pid_next;
            total_size_reg <= total_size_next;
            fit_mode_reg   <= fit_mode_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fidx_reg        <= fidx_next;
        oidx_reg        <= oidx_next;
        req_reg         <= req_next;
        tpid_reg        <= tpid_next;
        pick_found_reg  <= pick_found_next;
        pick_idx_reg    <= pick_idx_next;
        pick_start_reg  <= pick_start_next;
        pick_len_reg    <= pick_len_next;
        sum_reg         <= sum_next;
        addr_reg        <= addr_next;
        rank_reg        <= rank_next;
        slot_found_reg  <= slot_found_next;
        slot_idx_reg    <= slot_idx_next;
        start_reg       <= start_next;
        grant_reg       <= grant_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_age_reg     <= hit_age_next;
        left_found_reg  <= left_found_next;
        left_idx_reg    <= left_idx_next;
        left_start_reg  <= left_start_next;
        left_len_reg    <= left_len_next;
        right_found_reg <= right_found_next;
        right_idx_reg   <= right_idx_next;
        right_len_reg   <= right_len_next;
        fslot_found_reg <= fslot_found_next;
        fslot_idx_reg   <= fslot_idx_next;
        res_status_reg  <= res_status_next;
        res_pid_reg     <= res_pid_next;
        res_start_reg   <= res_start_next;
        res_size_reg    <= res_size_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

`ifndef NO_ASSERTIONS
    a_cnt_match: assert property (@(posedge aclk) disable iff (!aresetn)
        own_cnt_reg == ($countones(own_used_reg)))
        else $error("owner count out of step with owner valid bits");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fpa_pkg::S_IDLE) |-> (!f_we && !o_we))
        else $error("table write while idle");

    a_size_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_total_wr && state_reg == fpa_pkg::S_IDLE) |=> !s_tready)
        else $error("beat taken before free table reseeded");

    a_own_wr_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fpa_pkg::S_OWN_WR) |-> (slot_found_reg && !own_used_reg[slot_idx_reg]))
        else $error("owner written without a free slot");
`endif

endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFREE     = fpa_pkg::FREE_SLOTS_DEF;
    localparam int NOWN      = fpa_pkg::OWN_SLOTS_DEF;
    localparam int MIN_FRAG  = fpa_pkg::MIN_FRAGMENT_DEF;
    localparam int WD_LIMIT  = 40000;
    localparam int TAIL_WAIT = 300;
    localparam logic FUNC_RELEASE = 1'b1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_ODD   = 2'd3;

    typedef struct packed {
        fpa_pkg::status_t status;
        logic [7:0]       pid;
        logic [15:0]      start;
        logic [15:0]      size;
    } grant_t;

    // Allocator predictor plus queue of pending grants.
    class alloc_scoreboard;
        int unsigned total;
        logic [1:0]  mode;
        int unsigned fr_start [NFREE];
        int unsigned fr_len   [NFREE];
        bit          fr_used  [NFREE];
        logic [7:0]  ow_pid   [NOWN];
        int unsigned ow_start [NOWN];
        int unsigned ow_len   [NOWN];
        int unsigned ow_age   [NOWN];
        bit          ow_used  [NOWN];
        logic [7:0]  pid_ctr;
        grant_t      pending [$];
        int          errors;

        function void clear_tables();
            for (int i = 0; i < NFREE; i++) begin
                fr_start[i] = 0; fr_len[i] = 0; fr_used[i] = 0;
            end
            for (int i = 0; i < NOWN; i++) begin
                ow_pid[i] = 0; ow_start[i] = 0; ow_len[i] = 0;
                ow_age[i] = 0; ow_used[i] = 0;
            end
            if (total != 0) begin
                fr_len[0] = total; fr_used[0] = 1;
            end
        endfunction

        function void reset_state();
            total = 1024; mode = fpa_pkg::FIT_FIRST; pid_ctr = 0; errors = 0;
            clear_tables();
        endfunction

        function void write_reg(bit idx, logic [31:0] val);
            if (idx == fpa_pkg::REG_TOTAL) begin
                total = val[15:0];
                clear_tables();
            end else begin
                mode = val[1:0];
            end
        endfunction

        function bit prefer(int a, int b);
            if (b < 0) return 1;
            if (mode == fpa_pkg::FIT_BEST) begin
                if (fr_len[a] != fr_len[b]) return fr_len[a] < fr_len[b];
            end else if (mode != fpa_pkg::FIT_FIRST) begin
                if (fr_len[a] != fr_len[b]) return fr_len[a] > fr_len[b];
            end
            return fr_start[a] < fr_start[b];
        endfunction

        // Pack owned extents from zero, newest first; free space becomes one tail.
        function void pack_owned();
            int unsigned addr;
            addr = 0;
            for (int r = 0; r < NOWN; r++)
                for (int i = 0; i < NOWN; i++)
                    if (ow_used[i] && ow_age[i] == r) begin
                        ow_start[i] = addr;
                        addr = (addr + ow_len[i]) & 16'hFFFF;
                    end
            for (int i = 0; i < NFREE; i++) begin
                fr_used[i] = 0; fr_start[i] = 0; fr_len[i] = 0;
            end
            fr_start[0] = addr;
        endfunction

        function grant_t do_alloc(int unsigned req);
            grant_t g;
            int slot, pick;
            int unsigned st, gr, rem, sum;
            slot = -1; pick = -1; sum = 0;
            g = '0;
            pid_ctr = pid_ctr + 8'd1;
            g.pid = pid_ctr;
            g.status = fpa_pkg::STAT_FULL;
            if (req == 0) return g;
            for (int i = 0; i < NOWN; i++)
                if (!ow_used[i] && slot < 0) slot = i;
            if (slot < 0) return g;
            for (int i = 0; i < NFREE; i++)
                if (fr_used[i] && fr_len[i] >= req && prefer(i, pick)) pick = i;
            if (pick < 0) begin
                for (int i = 0; i < NFREE; i++)
                    if (fr_used[i]) sum += fr_len[i];
                if (sum < req) begin
                    g.status = fpa_pkg::STAT_NOMEM;
                    return g;
                end
                pack_owned();
                fr_len[0] = sum; fr_used[0] = 1; pick = 0;
            end
            st = fr_start[pick];
            rem = fr_len[pick] - req;
            if (rem > 0 && rem >= MIN_FRAG) begin
                gr = req;
                fr_start[pick] = (st + req) & 16'hFFFF;
                fr_len[pick] = rem;
            end else begin
                gr = fr_len[pick];
                fr_used[pick] = 0; fr_start[pick] = 0; fr_len[pick] = 0;
            end
            for (int i = 0; i < NOWN; i++)
                if (ow_used[i]) ow_age[i]++;
            ow_used[slot] = 1; ow_pid[slot] = pid_ctr;
            ow_start[slot] = st; ow_len[slot] = gr; ow_age[slot] = 0;
            g.status = fpa_pkg::STAT_OK; g.start = st; g.size = gr;
            return g;
        endfunction

        function grant_t do_release(logic [7:0] id);
            grant_t g;
            int hit, lft, rgt, slot;
            int unsigned s, l, e;
            hit = -1; lft = -1; rgt = -1; slot = -1;
            g = '0;
            g.pid = id;
            for (int i = 0; i < NOWN; i++)
                if (ow_used[i] && ow_pid[i] == id && (hit < 0 || ow_age[i] > ow_age[hit]))
                    hit = i;
            if (hit < 0) begin
                g.status = fpa_pkg::STAT_NOID;
                return g;
            end
            s = ow_start[hit]; l = ow_len[hit]; e = (s + l) & 16'hFFFF;
            for (int i = 0; i < NFREE; i++) begin
                if (!fr_used[i]) begin
                    if (slot < 0) slot = i;
                end else if (((fr_start[i] + fr_len[i]) & 16'hFFFF) == s && lft < 0) begin
                    lft = i;
                end else if (fr_start[i] == e && rgt < 0) begin
                    rgt = i;
                end
            end
            if (lft >= 0 && rgt >= 0) begin
                fr_len[lft] += l + fr_len[rgt];
                fr_used[rgt] = 0; fr_start[rgt] = 0; fr_len[rgt] = 0;
            end else if (lft >= 0) begin
                fr_len[lft] += l;
            end else if (rgt >= 0) begin
                fr_start[rgt] = s; fr_len[rgt] += l;
            end else if (slot >= 0) begin
                fr_used[slot] = 1; fr_start[slot] = s; fr_len[slot] = l;
            end else begin
                g.status = fpa_pkg::STAT_FULL;
                return g;
            end
            for (int i = 0; i < NOWN; i++)
                if (ow_used[i] && ow_age[i] > ow_age[hit]) ow_age[i]--;
            ow_used[hit] = 0;
            g.status = fpa_pkg::STAT_OK; g.start = s; g.size = l;
            return g;
        endfunction

        function void note_request(logic fn, logic [15:0] req, logic [7:0] id);
            if (fn == fpa_pkg::FUNC_ALLOC) pending.push_back(do_alloc(req));
            else pending.push_back(do_release(id));
        endfunction

        function void check_grant(grant_t act);
            grant_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $realtime, act);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (act.status !== exp.status) begin
                $display("%0t: status exp %0d act %0d", $realtime, exp.status, act.status);
                errors++;
            end
            if (act.pid !== exp.pid) begin
                $display("%0t: pid exp %0d act %0d", $realtime, exp.pid, act.pid);
                errors++;
            end
            if (act.start !== exp.start) begin
                $display("%0t: start exp %0d act %0d", $realtime, exp.start, act.start);
                errors++;
            end
            if (act.size !== exp.size) begin
                $display("%0t: size exp %0d act %0d", $realtime, exp.size, act.size);
                errors++;
            end
        endfunction

        // Random live id, or a random one when nothing is owned.
        function logic [7:0] live_pid();
            int picks [$];
            for (int i = 0; i < NOWN; i++)
                if (ow_used[i]) picks.push_back(i);
            if (picks.size() == 0) return 8'($urandom);
            return ow_pid[picks[$urandom_range(0, picks.size() - 1)]];
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] req_size, [23:16] target_pid
    logic [0:0]  s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [7:0] pid_out, [23:8] base_addr, [39:24] granted_size
    logic [1:0]  m_tuser;   // [1:0] status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alloc_scoreboard sb;
    int idle_cycles;
    bit rx_open;

    partition_allocator_ff_bf_wf u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: alternate between open stretches and random stalling.
    initial begin
        int left;
        m_tready = 1'b0;
        rx_open = 1'b1;
        left = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                rx_open = ($urandom_range(0, 2) == 0);
                left = $urandom_range(5, 60);
            end
            left--;
            m_tready = rx_open ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // Check every result beat at the edge that takes it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_grant({fpa_pkg::status_t'(m_tuser), m_tdata[7:0], m_tdata[23:8],
                            m_tdata[39:24]});
    end

    // Watchdog: count cycles with no beat on any port.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: watchdog expired", $realtime);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold one beat on the input channel until it is taken; leave tvalid high.
    task automatic send_beat(logic fn, logic [15:0] req, logic [7:0] id);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {id, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(fn, req, id);
    endtask

    task automatic drop_valid(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    // Drain all results, then let a worst-case free scan run out.
    task automatic drain();
        drop_valid(1);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    task automatic apb_write(bit idx, logic [31:0] val);
        drain();
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // One random request shaped by the current memory size.
    task automatic random_beat();
        int unsigned cap;
        int r;
        cap = (sb.total / 5 > 1) ? sb.total / 5 : 1;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_beat(fpa_pkg::FUNC_ALLOC, 16'($urandom_range(1, cap)), 8'($urandom));
        end else if (r < 54) begin
            send_beat(fpa_pkg::FUNC_ALLOC, 16'd0, 8'($urandom));
        end else if (r < 60) begin
            send_beat(fpa_pkg::FUNC_ALLOC, 16'($urandom), 8'($urandom));
        end else if (r < 92) begin
            send_beat(FUNC_RELEASE, 16'($urandom), sb.live_pid());
        end else begin
            send_beat(FUNC_RELEASE, 16'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_phase(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            int burst;
            burst = $urandom_range(1, 10);
            for (int k = 0; k < burst && sent < count; k++) begin
                random_beat();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) drop_valid($urandom_range(1, 6));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        idle_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Zero size is rejected; sixteen grants fill the owned table.
        send_beat(fpa_pkg::FUNC_ALLOC, 16'd0, 8'd0);
        for (int k = 0; k < NOWN; k++) send_beat(fpa_pkg::FUNC_ALLOC, 16'd60, 8'd0);
        send_beat(fpa_pkg::FUNC_ALLOC, 16'd10, 8'd0);
        // Punch two holes, try an unknown id, then force compaction.
        send_beat(FUNC_RELEASE, 16'hFFFF, 8'd3);
        send_beat(FUNC_RELEASE, 16'd0, 8'd5);
        send_beat(FUNC_RELEASE, 16'd0, 8'd200);
        send_beat(fpa_pkg::FUNC_ALLOC, 16'd150, 8'hFF);
        // Free the oldest extent, then ask for more than exists.
        send_beat(FUNC_RELEASE, 16'd0, 8'd2);
        send_beat(fpa_pkg::FUNC_ALLOC, 16'hFFFF, 8'd0);
        drain();

        apb_write(fpa_pkg::REG_TOTAL, 32'd1024);
        random_phase(60);
        apb_write(fpa_pkg::REG_FIT, {30'd0, fpa_pkg::FIT_BEST});
        random_phase(60);
        // Pause until every grant is back, then resume.
        drain();
        random_phase(20);
        apb_write(fpa_pkg::REG_TOTAL, 32'd65535);
        apb_write(fpa_pkg::REG_FIT, {30'd0, FIT_WORST});
        random_phase(60);
        apb_write(fpa_pkg::REG_TOTAL, 32'd200);
        apb_write(fpa_pkg::REG_FIT, {30'd0, FIT_ODD});
        random_phase(60);
        apb_write(fpa_pkg::REG_TOTAL, 32'd64);
        apb_write(fpa_pkg::REG_FIT, {30'd0, fpa_pkg::FIT_BEST});
        random_phase(50);
        apb_write(fpa_pkg::REG_TOTAL, 32'd1);
        apb_write(fpa_pkg::REG_FIT, {30'd0, fpa_pkg::FIT_FIRST});
        random_phase(20);
        apb_write(fpa_pkg::REG_TOTAL, 32'd0);
        random_phase(8);
        apb_write(fpa_pkg::REG_TOTAL, 32'd512);
        random_phase(60);

        drain();
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
